@@ design/gdgo_pkg.sv @@
`default_nettype none

package gdgo_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_RATE_LIMIT     = 2'd0;
  localparam logic [1:0] CFG_RATE_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_RETURN_SPEED   = 2'd2;
  localparam logic [1:0] CFG_FOLLOW_GAIN    = 2'd3;

  // Register values after reset.
  localparam logic [14:0] RATE_LIMIT_RST     = 15'd2560;
  localparam logic [14:0] RATE_THRESHOLD_RST = 15'd512;
  localparam logic [15:0] RETURN_SPEED_RST   = 16'd3277;
  localparam logic [15:0] FOLLOW_GAIN_RST    = 16'd6554;

  // 1.0 in Q8.8 (indicator on first crossing) and in Q2.14 (goal ceiling).
  localparam logic signed [16:0] IND_ONE_Q8 = 17'sd256;
  localparam logic [14:0]        ONE_Q14    = 15'd16384;

  // The goal divider retires this many quotient bits per cycle.
  localparam int unsigned DIV_BITS_PER_CYCLE = 4;
  localparam int unsigned DIV_CYCLES         = 4;
  localparam logic [1:0]  DIV_LAST           = 2'(DIV_CYCLES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_DIVIDE,
    ST_GOAL,
    ST_FOLLOW
  } state_e;

  // Strobes from the sequencer to both axis lanes.
  typedef struct packed {
    logic capture;
    logic update;
    logic load;
    logic div_step;
    logic goal;
  } lane_ctrl_t;

endpackage

`default_nettype wire

@@ design/gdgo_lane.sv @@
`default_nettype none

module gdgo_lane (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire gdgo_pkg::lane_ctrl_t ctrl_i,
  input  wire logic signed [15:0] rate_i,
  input  wire logic signed [15:0] eye_i,
  input  wire logic [14:0]        rate_limit_i,
  input  wire logic [14:0]        rate_threshold_i,
  input  wire logic [15:0]        return_speed_i,
  input  wire logic [15:0]        follow_gain_i,
  output logic signed [15:0]      eye_o,
  output logic                    tracking_o
);

  logic signed [15:0] rate_q, eye_q;
  logic signed [16:0] ind_q, ind_d, pw_q, pw_d;
  logic [14:0]        rem_q, rem_d;
  logic [15:0]        num_q, num_d, quo_q, quo_d;
  logic               sat_q, zero_q, neg_q;
  logic signed [16:0] goal_q, goal_d;

  // Axis update: clamp, indicator, latch or decay.
  logic signed [16:0] lim_s, rate_ext, r, ind_mid;
  logic [16:0]        ar, pw_mag;
  logic [32:0]        dec_prod;
  logic [15:0]        dec_mag;
  logic               latch;

  always_comb begin
    lim_s    = signed'({2'b00, rate_limit_i});
    rate_ext = 17'(rate_q);
    if (rate_ext > lim_s) begin
      r = lim_s;
    end else if (rate_ext < -lim_s) begin
      r = -lim_s;
    end else begin
      r = rate_ext;
    end
    ar = r[16] ? 17'(-r) : 17'(r);

    if (ind_q == 17'sd0 && ar > {2'b00, rate_threshold_i}) begin
      ind_mid = (r > 17'sd0) ? gdgo_pkg::IND_ONE_Q8 : -gdgo_pkg::IND_ONE_Q8;
    end else if (ind_q != 17'sd0 && ar < {2'b00, rate_threshold_i}) begin
      ind_mid = 17'sd0;
    end else begin
      ind_mid = ind_q;
    end
    latch = (ind_mid > 17'sd0 && r > ind_mid) || (ind_mid < 17'sd0 && r < ind_mid);

    pw_mag   = pw_q[16] ? 17'(-pw_q) : 17'(pw_q);
    dec_prod = {1'b0, 32'(pw_mag[15:0]) * 32'(return_speed_i)} + 33'd32768;
    dec_mag  = pw_mag[15:0] - dec_prod[31:16];

    if (latch) begin
      ind_d = (ind_mid > 17'sd0) ? lim_s : -lim_s;
      pw_d  = ind_d;
    end else begin
      ind_d = ind_mid;
      pw_d  = pw_q[16] ? -signed'({1'b0, dec_mag}) : signed'({1'b0, dec_mag});
    end
  end

  // Goal divider: restoring division, several quotient bits per cycle.
  logic [30:0] dividend;
  logic [15:0] rem_ext;
  logic [14:0] rem_v;
  logic [15:0] num_v, quo_v;
  logic [14:0] t_mag;

  always_comb begin
    dividend = {1'b0, pw_mag[15:0], 14'd0} + 31'(rate_limit_i >> 1);
    rem_v    = rem_q;
    num_v    = num_q;
    quo_v    = quo_q;
    rem_ext  = '0;
    for (int i = 0; i < int'(gdgo_pkg::DIV_BITS_PER_CYCLE); i++) begin
      rem_ext = {rem_v, num_v[15]};
      if (rem_ext >= {1'b0, rate_limit_i}) begin
        rem_ext = rem_ext - {1'b0, rate_limit_i};
        quo_v   = {quo_v[14:0], 1'b1};
      end else begin
        quo_v   = {quo_v[14:0], 1'b0};
      end
      rem_v = rem_ext[14:0];
      num_v = {num_v[14:0], 1'b0};
    end
    rem_d = rem_v;
    num_d = num_v;
    quo_d = quo_v;

    if (zero_q) begin
      t_mag = '0;
    end else if (sat_q || quo_q > {1'b0, gdgo_pkg::ONE_Q14}) begin
      t_mag = gdgo_pkg::ONE_Q14;
    end else begin
      t_mag = quo_q[14:0];
    end
    goal_d = neg_q ? -signed'({2'b00, t_mag}) : signed'({2'b00, t_mag});
  end

  // Follow: while tracking, move the eye target toward the goal by the follow gain; otherwise it passes through.
  logic signed [17:0] eye_ext, d, res;
  logic [17:0]        ad;
  logic [33:0]        fol_prod;
  logic [16:0]        st;

  always_comb begin
    eye_ext  = 18'(eye_q);
    d        = 18'(goal_q) - eye_ext;
    ad       = d[17] ? 18'(-d) : 18'(d);
    fol_prod = {1'b0, 33'(ad[16:0]) * 33'(follow_gain_i)} + 34'd32768;
    st       = fol_prod[32:16];
    res      = d[17] ? eye_ext - signed'({1'b0, st}) : eye_ext + signed'({1'b0, st});
    tracking_o = (ind_q != 17'sd0);
    eye_o      = tracking_o ? res[15:0] : eye_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ind_q <= '0;
      pw_q  <= '0;
    end else if (ctrl_i.update) begin
      ind_q <= ind_d;
      pw_q  <= pw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      rate_q <= rate_i;
      eye_q  <= eye_i;
    end
    if (ctrl_i.load) begin
      rem_q  <= dividend[30:16];
      num_q  <= dividend[15:0];
      quo_q  <= '0;
      sat_q  <= (pw_mag[15:0] >= {1'b0, rate_limit_i});
      zero_q <= (rate_limit_i == '0);
      neg_q  <= pw_q[16];
    end else if (ctrl_i.div_step) begin
      rem_q <= rem_d;
      num_q <= num_d;
      quo_q <= quo_d;
    end
    if (ctrl_i.goal) begin
      goal_q <= goal_d;
    end
  end

endmodule

`default_nettype wire

@@ design/gyro_driven_gaze_offset.sv @@
`default_nettype none

// Gyro-driven gaze offset. Each item carries a pan and a tilt head rate
// (signed Q8.8) and the current horizontal and vertical eye targets (signed
// Q2.14); it returns exactly one item with the updated eye targets and the two
// tracking flags. The pan and tilt axes run in two identical lanes side by side,
// each holding its own tracking indicator and power value, and the output
// register merges both lanes into one result item. After acceptance an item
// passes through the axis update, the load of the goal divider, the divider
// itself (it retires four quotient bits per cycle of the sixteen it needs), the
// forming of the goal and the follow multiply that writes the output register,
// after which the sequencer returns to idle, where the next item is accepted.
// The follow stage waits for as long as the output register still holds a
// stalled result. The input stall is raised for the whole of that sequence.
// The output register lets the next item enter while a finished result still
// waits to be taken.
// Configuration registers are written through a plain write port (enable, index
// and sixteen-bit data) and must only be written while the block is idle; they
// come out of reset with a rate limit of 10.0, a threshold of 2.0, a return
// speed of about 0.05 and a follow gain of about 0.1. A rate limit of zero makes
// every goal zero.

module gyro_driven_gaze_offset (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] pan_rate_i,
  input  wire logic signed [15:0] tilt_rate_i,
  input  wire logic signed [15:0] eye_x_in_i,
  input  wire logic signed [15:0] eye_y_in_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output logic signed [15:0]      eye_x_out_o,
  output logic signed [15:0]      eye_y_out_o,
  output logic                    pan_tracking_o,
  output logic                    tilt_tracking_o
);

  // Configuration registers.
  logic [14:0] rate_limit_q, rate_threshold_q;
  logic [15:0] return_speed_q, follow_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_limit_q     <= gdgo_pkg::RATE_LIMIT_RST;
      rate_threshold_q <= gdgo_pkg::RATE_THRESHOLD_RST;
      return_speed_q   <= gdgo_pkg::RETURN_SPEED_RST;
      follow_gain_q    <= gdgo_pkg::FOLLOW_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gdgo_pkg::CFG_RATE_LIMIT:     rate_limit_q     <= cfg_data_i[14:0];
        gdgo_pkg::CFG_RATE_THRESHOLD: rate_threshold_q <= cfg_data_i[14:0];
        gdgo_pkg::CFG_RETURN_SPEED:   return_speed_q   <= cfg_data_i;
        gdgo_pkg::CFG_FOLLOW_GAIN:    follow_gain_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer.
  gdgo_pkg::state_e     state_q, state_d;
  logic [1:0]           div_cnt_q;
  gdgo_pkg::lane_ctrl_t ctrl;
  logic                 in_fire, out_fire, out_free, follow_fire;
  logic                 out_valid_q;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_q && !out_stall_i;
  // The output register can take a new result when empty or being emptied.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      gdgo_pkg::ST_IDLE:   if (in_valid_i) state_d = gdgo_pkg::ST_UPDATE;
      gdgo_pkg::ST_UPDATE: state_d = gdgo_pkg::ST_LOAD;
      gdgo_pkg::ST_LOAD:   state_d = gdgo_pkg::ST_DIVIDE;
      gdgo_pkg::ST_DIVIDE: begin
        if (div_cnt_q == gdgo_pkg::DIV_LAST) state_d = gdgo_pkg::ST_GOAL;
      end
      gdgo_pkg::ST_GOAL:   state_d = gdgo_pkg::ST_FOLLOW;
      gdgo_pkg::ST_FOLLOW: if (out_free) state_d = gdgo_pkg::ST_IDLE;
      default:             state_d = gdgo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl        = '0;
    in_stall_o  = 1'b1;
    follow_fire = 1'b0;
    case (state_q)
      gdgo_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        ctrl.capture = in_valid_i;
      end
      gdgo_pkg::ST_UPDATE: ctrl.update   = 1'b1;
      gdgo_pkg::ST_LOAD:   ctrl.load     = 1'b1;
      gdgo_pkg::ST_DIVIDE: ctrl.div_step = 1'b1;
      gdgo_pkg::ST_GOAL:   ctrl.goal     = 1'b1;
      gdgo_pkg::ST_FOLLOW: follow_fire   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gdgo_pkg::ST_IDLE;
      div_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (ctrl.load) begin
        div_cnt_q <= '0;
      end else if (ctrl.div_step) begin
        div_cnt_q <= div_cnt_q + 2'd1;
      end
    end
  end

  // The two axis lanes.
  logic signed [15:0] pan_eye, tilt_eye;
  logic               pan_trk, tilt_trk;

  gdgo_lane u_pan (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .rate_i           (pan_rate_i),
    .eye_i            (eye_x_in_i),
    .rate_limit_i     (rate_limit_q),
    .rate_threshold_i (rate_threshold_q),
    .return_speed_i   (return_speed_q),
    .follow_gain_i    (follow_gain_q),
    .eye_o            (pan_eye),
    .tracking_o       (pan_trk)
  );

  gdgo_lane u_tilt (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .rate_i           (tilt_rate_i),
    .eye_i            (eye_y_in_i),
    .rate_limit_i     (rate_limit_q),
    .rate_threshold_i (rate_threshold_q),
    .return_speed_i   (return_speed_q),
    .follow_gain_i    (follow_gain_q),
    .eye_o            (tilt_eye),
    .tracking_o       (tilt_trk)
  );

  // Output register: merges both lanes into one result item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (follow_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (follow_fire) begin
      eye_x_out_o     <= pan_eye;
      eye_y_out_o     <= tilt_eye;
      pan_tracking_o  <= pan_trk;
      tilt_tracking_o <= tilt_trk;
    end
  end

  assign out_valid_o = out_valid_q;

  // An accepted item always goes straight into the axis update.
  a_accept_to_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == gdgo_pkg::ST_UPDATE)
    else $error("accepted item did not start the axis update");

  // On its last step the divider hands over to the goal stage.
  a_divide_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gdgo_pkg::ST_DIVIDE && div_cnt_q == gdgo_pkg::DIV_LAST)
    |=> state_q == gdgo_pkg::ST_GOAL)
    else $error("divider did not finish on its last step");

  // A result written by the follow stage is presented on the next cycle.
  a_follow_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    follow_fire |=> out_valid_o)
    else $error("finished result not presented");

  // The lanes never receive two strobes at once.
  a_ctrl_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(ctrl))
    else $error("lane strobes overlap");

endmodule

`default_nettype wire

@@ bench/gaze_checker.sv @@
`timescale 1ns / 100ps

module gaze_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [15:0]              cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic signed [15:0]       pan_rate_i,
  input  logic signed [15:0]       tilt_rate_i,
  input  logic signed [15:0]       eye_x_in_i,
  input  logic signed [15:0]       eye_y_in_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [15:0]       eye_x_out_i,
  input  logic signed [15:0]       eye_y_out_i,
  input  logic                     pan_tracking_i,
  input  logic                     tilt_tracking_i,
  output int unsigned              mismatch_count_o,
  output int unsigned              backlog_o
);

  typedef struct packed {
    logic signed [16:0] ind;
    logic signed [16:0] pwr;
  } axis_t;

  typedef struct packed {
    logic signed [15:0] eye_x;
    logic signed [15:0] eye_y;
    logic               pan_trk;
    logic               tilt_trk;
  } gaze_t;

  logic [14:0] lim_q;
  logic [14:0] thr_q;
  logic [15:0] spd_q;
  logic [15:0] gain_q;
  axis_t       pan_q;
  axis_t       tilt_q;
  gaze_t       expected_gaze[$];
  int unsigned mismatches = 0;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("gaze_checker: %s", msg);
    mismatches++;
  endtask

  // Advances one axis by one rate sample and returns its goal in Q2.14.
  function automatic int step_axis(input logic signed [15:0] rate, inout axis_t ax);
    int     lim;
    int     thr;
    int     r;
    int     ar;
    int     ind;
    int     pwr;
    longint m;
    longint t;
    bit     neg;
    lim = int'(lim_q);
    thr = int'(thr_q);
    r   = int'(rate);
    if (r > lim) r = lim;
    else if (r < -lim) r = -lim;
    ar  = (r < 0) ? -r : r;
    ind = int'(ax.ind);
    pwr = int'(ax.pwr);

    if (ind == 0 && ar > thr) begin
      ind = (r > 0) ? int'(gdgo_pkg::IND_ONE_Q8) : -int'(gdgo_pkg::IND_ONE_Q8);
    end else if (ind != 0 && ar < thr) begin
      ind = 0;
    end

    // A rate beyond the indicator snaps both indicator and power to the limit.
    if ((ind > 0 && r > ind) || (ind < 0 && r < ind)) begin
      ind = (ind > 0) ? lim : -lim;
      pwr = ind;
    end else begin
      neg = (pwr < 0);
      m   = neg ? -longint'(pwr) : longint'(pwr);
      m   = m - ((m * longint'(spd_q) + 64'sd32768) >>> 16);
      pwr = neg ? -int'(m) : int'(m);
    end
    ax.ind = 17'(ind);
    ax.pwr = 17'(pwr);

    if (lim == 0) return 0;
    neg = (pwr < 0);
    m   = neg ? -longint'(pwr) : longint'(pwr);
    t   = (m * 64'sd16384 + longint'(lim / 2)) / longint'(lim);
    if (t > longint'(gdgo_pkg::ONE_Q14)) t = longint'(gdgo_pkg::ONE_Q14);
    return neg ? -int'(t) : int'(t);
  endfunction

  // Moves the eye target toward the goal by the follow gain, rounded.
  function automatic int glide(input int eye, input int goal);
    int     d;
    longint ad;
    int     stride;
    d      = goal - eye;
    ad     = (d < 0) ? -longint'(d) : longint'(d);
    stride = int'((ad * longint'(gain_q) + 64'sd32768) >>> 16);
    return (d < 0) ? eye - stride : eye + stride;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    gaze_t want;
    int    gx;
    int    gy;
    int    ex;
    int    ey;
    if (!rst_ni) begin
      lim_q  = gdgo_pkg::RATE_LIMIT_RST;
      thr_q  = gdgo_pkg::RATE_THRESHOLD_RST;
      spd_q  = gdgo_pkg::RETURN_SPEED_RST;
      gain_q = gdgo_pkg::FOLLOW_GAIN_RST;
      pan_q  = '0;
      tilt_q = '0;
      expected_gaze.delete();
      backlog_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gdgo_pkg::CFG_RATE_LIMIT:     lim_q  = cfg_data_i[14:0];
          gdgo_pkg::CFG_RATE_THRESHOLD: thr_q  = cfg_data_i[14:0];
          gdgo_pkg::CFG_RETURN_SPEED:   spd_q  = cfg_data_i;
          gdgo_pkg::CFG_FOLLOW_GAIN:    gain_q = cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (expected_gaze.size() == 0) begin
          report_mismatch($sformatf("result x=%0d y=%0d arrived with nothing expected",
                                    eye_x_out_i, eye_y_out_i));
        end else begin
          want = expected_gaze.pop_front();
          if (eye_x_out_i !== want.eye_x)
            report_mismatch($sformatf("eye_x_out got %0d, expected %0d",
                                      eye_x_out_i, want.eye_x));
          if (eye_y_out_i !== want.eye_y)
            report_mismatch($sformatf("eye_y_out got %0d, expected %0d",
                                      eye_y_out_i, want.eye_y));
          if (pan_tracking_i !== want.pan_trk)
            report_mismatch($sformatf("pan_tracking got %b, expected %b",
                                      pan_tracking_i, want.pan_trk));
          if (tilt_tracking_i !== want.tilt_trk)
            report_mismatch($sformatf("tilt_tracking got %b, expected %b",
                                      tilt_tracking_i, want.tilt_trk));
        end
      end

      if (in_valid_i && !in_stall_i) begin
        gx = step_axis(pan_rate_i, pan_q);
        gy = step_axis(tilt_rate_i, tilt_q);
        ex = int'(eye_x_in_i);
        ey = int'(eye_y_in_i);
        if (pan_q.ind != 0) ex = glide(ex, gx);
        if (tilt_q.ind != 0) ey = glide(ey, gy);
        want.eye_x    = 16'(ex);
        want.eye_y    = 16'(ey);
        want.pan_trk  = (pan_q.ind != 0);
        want.tilt_trk = (tilt_q.ind != 0);
        expected_gaze.push_back(want);
      end

      backlog_o <= expected_gaze.size();
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;

  // Drain time that covers the block's item sequence and the output register.
  localparam int DRAIN_CYCLES   = 16;
  // The receiver's long hold-off, long enough for the block to fill and stall.
  localparam int HOLD_CYCLES    = 400;
  // Cycles without any accepted item or register write before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 200;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [15:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] pan_rate_i;
  logic signed [15:0] tilt_rate_i;
  logic signed [15:0] eye_x_in_i;
  logic signed [15:0] eye_y_in_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] eye_x_out_o;
  logic signed [15:0] eye_y_out_o;
  logic               pan_tracking_o;
  logic               tilt_tracking_o;
  int unsigned        mismatch_count;
  int unsigned        backlog;

  // Current register settings, kept here only to shape the stimulus.
  int cur_lim;
  int cur_thr;
  // Items still to go in the sender's current burst.
  int burst_left;
  int quiet_cycles = 0;
  // High while a random phase still has plenty of items to offer.
  bit phase_busy = 1'b0;

  gyro_driven_gaze_offset dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pan_rate_i      (pan_rate_i),
    .tilt_rate_i     (tilt_rate_i),
    .eye_x_in_i      (eye_x_in_i),
    .eye_y_in_i      (eye_y_in_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .eye_x_out_o     (eye_x_out_o),
    .eye_y_out_o     (eye_y_out_o),
    .pan_tracking_o  (pan_tracking_o),
    .tilt_tracking_o (tilt_tracking_o)
  );

  // The checker sits beside the block, watching both channels and the write port.
  gaze_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .pan_rate_i       (pan_rate_i),
    .tilt_rate_i      (tilt_rate_i),
    .eye_x_in_i       (eye_x_in_i),
    .eye_y_in_i       (eye_y_in_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .eye_x_out_i      (eye_x_out_o),
    .eye_y_out_i      (eye_y_out_o),
    .pan_tracking_i   (pan_tracking_o),
    .tilt_tracking_i  (tilt_tracking_o),
    .mismatch_count_o (mismatch_count),
    .backlog_o        (backlog)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Saturates a wide integer into the signed Q8.8 rate range.
  function automatic logic signed [15:0] to_rate(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // A rate clearly above the threshold, as seen while the head is turning.
  function automatic int motion_rate(input bit neg);
    int a;
    a = cur_thr + 1 + int'($urandom_range(0, 2 * cur_lim + 64));
    return neg ? -a : a;
  endfunction

  // A rate below the threshold, so that tracking ends and power decays.
  function automatic int quiet_rate();
    int a;
    if (cur_thr == 0) return 0;
    a = int'($urandom_range(0, cur_thr - 1));
    return $urandom_range(0, 1) ? -a : a;
  endfunction

  // Noise: full-range values and values sitting on the interesting boundaries.
  function automatic int edgy_rate();
    int v;
    case ($urandom_range(0, 5))
      0: return int'($urandom_range(0, 65535)) - 32768;
      1: v = cur_thr + int'($urandom_range(0, 4)) - 2;
      2: v = cur_lim + int'($urandom_range(0, 4)) - 2;
      3: v = int'(gdgo_pkg::IND_ONE_Q8) + int'($urandom_range(0, 2)) - 1;
      4: return 0;
      default: return $urandom_range(0, 1) ? 32767 : -32768;
    endcase
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // Eye targets are mostly within plus or minus 1.0, sometimes anywhere.
  function automatic int eye_pick();
    if ($urandom_range(0, 4) != 0) return int'($urandom_range(0, 32768)) - 16384;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Offers one item and waits until the block takes it. The sender works in
  // bursts; between bursts valid drops for a random gap.
  task automatic send_item(input int pan, input int tilt, input int ex, input int ey);
    int gap;
    in_valid_i  <= 1'b1;
    pan_rate_i  <= to_rate(pan);
    tilt_rate_i <= to_rate(tilt);
    eye_x_in_i  <= 16'(ex);
    eye_y_in_i  <= 16'(ey);
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    if (burst_left <= 0) begin
      // Now and then a long burst gives a stretch with no idling at all.
      burst_left = ($urandom_range(0, 9) == 0) ? 100 : int'($urandom_range(1, 24));
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Waits until every expected result has been taken and the block is idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (backlog != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // The enable stays high here; the caller drops it after the last write.
  task automatic write_reg(input logic [1:0] idx, input int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= 16'(value);
    @(posedge clk_i);
  endtask

  // Registers are only rewritten once the block has gone idle.
  task automatic apply_setting(input int lim, input int thr, input int spd, input int gain);
    settle();
    write_reg(gdgo_pkg::CFG_RATE_LIMIT, lim);
    write_reg(gdgo_pkg::CFG_RATE_THRESHOLD, thr);
    write_reg(gdgo_pkg::CFG_RETURN_SPEED, spd);
    write_reg(gdgo_pkg::CFG_FOLLOW_GAIN, gain);
    cfg_we_i <= 1'b0;
    cur_lim = lim;
    cur_thr = thr;
  endtask

  // Random part: mostly head movements (a run of fast samples, then a run of
  // slow ones) with random content, and the rest noise on the boundaries.
  task automatic run_phase(input int count);
    int sent;
    int on_len;
    int off_len;
    int k;
    bit pan_neg;
    bit tilt_neg;
    bit pan_on;
    bit tilt_on;
    sent = 0;
    while (sent < count) begin
      phase_busy = (sent + 16 < count);
      if ($urandom_range(0, 9) < 7) begin
        on_len   = $urandom_range(1, 8);
        off_len  = $urandom_range(1, 6);
        pan_neg  = $urandom_range(0, 1);
        tilt_neg = $urandom_range(0, 1);
        pan_on   = ($urandom_range(0, 4) != 0);
        tilt_on  = ($urandom_range(0, 4) != 0);
        for (k = 0; k < on_len; k++) begin
          send_item(pan_on ? motion_rate(pan_neg) : quiet_rate(),
                    tilt_on ? motion_rate(tilt_neg) : quiet_rate(),
                    eye_pick(), eye_pick());
        end
        for (k = 0; k < off_len; k++) begin
          send_item(quiet_rate(), quiet_rate(), eye_pick(), eye_pick());
        end
        sent += on_len + off_len;
      end else begin
        on_len = $urandom_range(1, 4);
        for (k = 0; k < on_len; k++) begin
          send_item(edgy_rate(), edgy_rate(), eye_pick(), eye_pick());
        end
        sent += on_len;
      end
    end
    phase_busy = 1'b0;
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= gdgo_pkg::CFG_RATE_LIMIT;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    pan_rate_i  <= '0;
    tilt_rate_i <= '0;
    eye_x_in_i  <= '0;
    eye_y_in_i  <= '0;
    burst_left  = 1;
    cur_lim     = int'(gdgo_pkg::RATE_LIMIT_RST);
    cur_thr     = int'(gdgo_pkg::RATE_THRESHOLD_RST);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default settings, written explicitly.
    apply_setting(int'(gdgo_pkg::RATE_LIMIT_RST), int'(gdgo_pkg::RATE_THRESHOLD_RST),
                  int'(gdgo_pkg::RETURN_SPEED_RST), int'(gdgo_pkg::FOLLOW_GAIN_RST));
    // At rest the eye targets pass through unchanged.
    send_item(0, 0, 16384, -16384);
    // Full-scale rates clamp to the limit and latch the power.
    send_item(32767, -32768, 0, 0);
    // Holding at the limit does not pass the indicator, so the power decays.
    send_item(32767, -32768, 1000, -1000);
    // Rates drop to zero: tracking ends, and an out-of-range eye passes through.
    send_item(0, 0, 32767, -32768);
    // Exactly on the threshold does not start tracking.
    send_item(512, -512, 0, 0);
    // Just above it starts tracking and latches at once.
    send_item(513, -513, 100, -100);
    // On the threshold while tracking keeps tracking.
    send_item(512, -512, 0, 0);
    // Below the threshold tracking stops.
    send_item(257, -257, 0, 0);

    // A low threshold lets the indicator sit at 1.0 before the rate passes it.
    apply_setting(10000, 100, 0, 65535);
    send_item(200, -200, 0, 0);
    send_item(300, -300, 0, 0);
    send_item(10000, -10000, 32767, -32768);

    // The limit is lowered under the held power: the goal clamps to 1.0.
    apply_setting(1000, 100, 0, 65535);
    send_item(150, -150, 0, 0);
    send_item(-150, 150, 16384, -16384);

    // A zero limit makes every goal zero.
    apply_setting(0, 0, 65535, 32768);
    send_item(32767, -32768, 5000, -5000);
    send_item(0, 0, -5000, 5000);
    send_item(-32768, 32767, 0, 0);

    // Smallest nonzero limit, largest threshold, fastest return, no follow.
    apply_setting(1, 32767, 65535, 0);
    send_item(32767, -32768, 1234, -1234);
    send_item(1, -1, 0, 0);

    apply_setting(int'(gdgo_pkg::RATE_LIMIT_RST), int'(gdgo_pkg::RATE_THRESHOLD_RST),
                  int'(gdgo_pkg::RETURN_SPEED_RST), int'(gdgo_pkg::FOLLOW_GAIN_RST));
    run_phase(PHASE_ITEMS);
    apply_setting(32767, 0, 0, 65535);
    run_phase(PHASE_ITEMS);
    apply_setting(1, 32767, 65535, 0);
    run_phase(PHASE_ITEMS);
    apply_setting(0, $urandom_range(0, 600), $urandom_range(0, 65535), $urandom_range(0, 65535));
    run_phase(PHASE_ITEMS);
    apply_setting(300, 100, 20000, 40000);
    run_phase(PHASE_ITEMS);
    apply_setting($urandom_range(1, 32767), $urandom_range(0, 4000),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
    run_phase(PHASE_ITEMS);
    apply_setting($urandom_range(1, 4000), $urandom_range(0, 1000),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
    run_phase(PHASE_ITEMS);

    settle();
    if (mismatch_count == 0 && backlog == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // The receiver stalls on a pattern of its own: segments of random length,
  // each with its own stall density, and once a long hold-off while the sender
  // keeps offering items, so that the block backs up into its input.
  initial begin : receiver
    int seg;
    int len;
    int pct;
    seg = 0;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      seg++;
      if (seg == 12) begin
        // The hold-off waits for a random phase, so that items keep coming.
        out_stall_i <= 1'b0;
        do @(posedge clk_i); while (!phase_busy);
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        len = $urandom_range(16, 128);
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 25;
          2: pct = 60;
          default: pct = 90;
        endcase
        repeat (len) begin
          out_stall_i <= ($urandom_range(0, 99) < pct);
          @(posedge clk_i);
        end
      end
    end
  end

  // Abandons the run when nothing has moved for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
